### rtl/core/nlr_pkg.sv
// Shared types and constants of the numeric literal recognizer.
package nlr_pkg;

  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChLowE  = 8'h65;
  localparam logic [CharW-1:0] ChUpE   = 8'h45;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;

  typedef logic [CharW-1:0] char_t;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_BODY    = 3'd1,
    PH_EXPSIGN = 3'd2,
    PH_TRAIL   = 3'd3,
    PH_REJECT  = 3'd4
  } phase_t;

  typedef struct packed {
    logic is_ws;
    logic is_sign;
    logic is_digit;
    logic is_dot;
    logic is_exp;
  } char_class_t;

  typedef struct packed {
    phase_t phase;
    logic   digit_seen;
    logic   dot_seen;
    logic   exponent_seen;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    phase: PH_LEAD, digit_seen: 1'b0, dot_seen: 1'b0, exponent_seen: 1'b0
  };

endpackage

### rtl/core/nlr_ifs.sv
// Valid/ready channel interfaces for the byte input and the verdict output.
interface nlr_in_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           character;
  logic                 end_marker;

  modport source (output valid, output character, output end_marker, input ready);
  modport sink   (input valid, input character, input end_marker, output ready);
endinterface

interface nlr_out_if;
  logic valid;
  logic ready;
  logic is_number;

  modport source (output valid, output is_number, input ready);
  modport sink   (input valid, input is_number, output ready);
endinterface

### rtl/core/nlr_classify.sv
// Byte classifier: decodes one character into the classes the scanner uses.
module nlr_classify (
  input  nlr_pkg::char_t      char_i,
  output nlr_pkg::char_class_t cls_o
);
  import nlr_pkg::*;

  always_comb begin
    cls_o.is_ws    = (char_i inside {[ChTab:ChCr], ChSpace});
    cls_o.is_sign  = (char_i inside {ChPlus, ChMinus});
    cls_o.is_digit = (char_i inside {[ChZero:ChNine]});
    cls_o.is_dot   = (char_i == ChDot);
    cls_o.is_exp   = (char_i inside {ChLowE, ChUpE});
  end

endmodule

### rtl/core/nlr_scan.sv
// Scanner state machine: tracks phase and seen flags, gives the verdict.
module nlr_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_i,
  input  logic                 end_i,
  input  nlr_pkg::char_class_t cls_i,
  output logic                 verdict_o
);
  import nlr_pkg::*;

  scan_state_t st_r;
  scan_state_t st_nxt;

  // Mantissa or exponent byte.
  function automatic scan_state_t body_byte(scan_state_t s, char_class_t c);
    scan_state_t n;
    n = s;
    if (c.is_digit) begin
      n.digit_seen = 1'b1;
      n.phase      = PH_BODY;
    end else if (c.is_dot && !s.dot_seen && !s.exponent_seen) begin
      n.dot_seen = 1'b1;
      n.phase    = PH_BODY;
    end else if (c.is_exp && !s.exponent_seen && s.digit_seen) begin
      n.exponent_seen = 1'b1;
      n.digit_seen    = 1'b0;
      n.phase         = PH_EXPSIGN;
    end else if (c.is_ws) begin
      n.phase = PH_TRAIL;
    end else begin
      n.phase = PH_REJECT;
    end
    return n;
  endfunction

  // Next state.
  always_comb begin
    st_nxt = st_r;
    if (step_i) begin
      if (end_i) begin
        st_nxt = ScanReset;
      end else begin
        case (st_r.phase)
          PH_LEAD: begin
            if (cls_i.is_ws) begin
              st_nxt = st_r;
            end else if (cls_i.is_sign) begin
              st_nxt.phase = PH_BODY;
            end else begin
              st_nxt = body_byte(st_r, cls_i);
            end
          end
          PH_BODY: begin
            st_nxt = body_byte(st_r, cls_i);
          end
          PH_EXPSIGN: begin
            if (cls_i.is_sign) begin
              st_nxt.phase = PH_BODY;
            end else begin
              st_nxt = body_byte(st_r, cls_i);
            end
          end
          PH_TRAIL: begin
            if (!cls_i.is_ws) begin
              st_nxt.phase = PH_REJECT;
            end
          end
          default: begin
            st_nxt.phase = PH_REJECT;
          end
        endcase
      end
    end
  end

  // Outputs.
  always_comb begin
    verdict_o = (st_r.phase != PH_REJECT) && st_r.digit_seen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ScanReset;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && end_i |=> st_r == ScanReset)
    else $error("terminator did not clear scanner state");

  a_reject_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_REJECT && !(step_i && end_i) |=> st_r.phase == PH_REJECT)
    else $error("rejected string left the reject phase before terminator");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_i |=> $stable(st_r))
    else $error("scanner state moved without a step");

  a_exp_clears_digit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_EXPSIGN |-> st_r.exponent_seen && !st_r.digit_seen)
    else $error("exponent phase with inconsistent flags");

endmodule

### rtl/core/numeric_literal_recognizer_core.sv
// Numeric literal recognizer top level: input register, scanner, verdict register.
// A terminator accepted on in_ch passes the input register, then loads the verdict register that drives out_ch.
// Throughput: one byte per cycle except while a terminator stalls; the scanner takes one step per advanced byte.
// A terminator stalls the input only while the verdict register is still full and not taken.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner to the
// leading whitespace phase with all seen flags cleared.
module numeric_literal_recognizer_core (
  input  logic             clk,
  input  logic             rst_n,
  nlr_in_if.sink           in_ch,
  nlr_out_if.source        out_ch
);
  import nlr_pkg::*;

  // Input register stage.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  char_t       s1_char_r;
  char_t       s1_char_nxt;
  logic        s1_end_r;
  logic        s1_end_nxt;

  // Verdict register stage.
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_num_r;
  logic        out_num_nxt;

  logic        in_fire;
  logic        s1_fire;
  logic        verdict;
  char_class_t cls;

  // Advance the held byte unless it is a terminator facing a full verdict register.
  assign s1_fire  = s1_valid_r && (!s1_end_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  nlr_classify u_classify (
    .char_i (s1_char_r),
    .cls_o  (cls)
  );

  // The scanner state reflects every earlier byte, so the verdict is read as
  // the terminator advances and the state clears in the same cycle.
  nlr_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (s1_fire),
    .end_i     (s1_end_r),
    .cls_i     (cls),
    .verdict_o (verdict)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_char_nxt  = s1_char_r;
    s1_end_nxt   = s1_end_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_char_nxt  = in_ch.character;
      s1_end_nxt   = in_ch.end_marker;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_num_nxt   = out_num_r;
    if (s1_fire && s1_end_r) begin
      // Load a fresh verdict; the old one is either gone or taken this cycle.
      out_valid_nxt = 1'b1;
      out_num_nxt   = verdict;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    s1_char_r <= s1_char_nxt;
    s1_end_r  <= s1_end_nxt;
    out_num_r <= out_num_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_number = out_num_r;

endmodule
